// ===== rtl/assert_macros.svh =====
// assertion helpers shared by the rtl
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef NO_ASSERTIONS
// same-cycle implication
`define ASSERT_IMPLIES(name, clk, rst_n, ante, cons) \
	name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("assertion failed");
// next-cycle implication
`define ASSERT_NEXT(name, clk, rst_n, ante, cons) \
	name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("assertion failed");
`else
`define ASSERT_IMPLIES(name, clk, rst_n, ante, cons)
`define ASSERT_NEXT(name, clk, rst_n, ante, cons)
`endif

`endif

// ===== rtl/trmce_pkg.sv =====
package trmce_pkg;

	// opcodes
	localparam logic [2:0] MODE_MOV  = 3'd0;
	localparam logic [2:0] MODE_ADD  = 3'd1;
	localparam logic [2:0] MODE_SUB  = 3'd2;
	localparam logic [2:0] MODE_JZ   = 3'd3;
	localparam logic [2:0] MODE_JNP  = 3'd4;
	localparam logic [2:0] MODE_JMP  = 3'd5;
	localparam logic [2:0] MODE_PRN  = 3'd6;
	localparam logic [2:0] MODE_HLT  = 3'd7;

	// first operand kinds
	localparam logic FK_REG = 1'b0;
	localparam logic FK_MEM = 1'b1;

	// second operand kinds, the last one unused and read as zero
	localparam logic [1:0] SK_REG   = 2'd0;
	localparam logic [1:0] SK_CONST = 2'd1;
	localparam logic [1:0] SK_MEM   = 2'd2;
	localparam logic [1:0] SK_NONE  = 2'd3;

	typedef struct packed {
		logic [2:0]  mode;
		logic        first_kind;
		logic [1:0]  second_kind;
		logic [2:0]  first_reg;
		logic [2:0]  second_reg;
		logic [5:0]  mem_address;
		logic [30:0] constant_value;
		logic [7:0]  jump_target;
	} in_item_t;

	typedef struct packed {
		logic [7:0]         next_pc;
		logic               halted_flag;
		logic               print_valid;
		logic signed [31:0] print_value;
	} out_item_t;

	// source of the b operand
	typedef enum logic [2:0] {
		B_ZERO  = 3'd0,
		B_REGA  = 3'd1,
		B_REGB  = 3'd2,
		B_CONST = 3'd3,
		B_MEM   = 3'd4
	} bsel_t;

	// decoded micro-op passed from front to back
	typedef struct packed {
		logic        halt;
		logic        print;
		logic        jmp_any;
		logic        jmp_zero;
		logic        jmp_nonpos;
		logic        reg_wr;
		logic [2:0]  reg_dst;
		logic        mem_wr;
		logic [5:0]  mem_addr;
		logic        mem_rd_ok;
		logic [2:0]  ra;
		logic        ra_ok;
		logic [2:0]  rb;
		logic        rb_ok;
		logic        add_a;
		logic        sub;
		bsel_t       bsel;
		logic [30:0] konst;
		logic [7:0]  target;
		logic [7:0]  tq;
	} uop_t;

	typedef struct packed {
		logic halted;
		logic stage_full;
	} back_stat_t;

	function automatic bsel_t src_sel(logic [1:0] sk);
		bsel_t s;
		case (sk)
			SK_REG:   s = B_REGB;
			SK_CONST: s = B_CONST;
			SK_MEM:   s = B_MEM;
			default:  s = B_ZERO;
		endcase
		return s;
	endfunction

endpackage

// ===== rtl/trmce_front.sv =====
module trmce_front #(
	parameter int NUM_REGS   = 5,
	parameter int MEM_DEPTH  = 64,
	parameter int PROG_DEPTH = 256
) (
	input  logic                 in_valid,
	output logic                 in_ready,
	input  trmce_pkg::in_item_t  in_data,
	output logic                 uop_valid,
	input  logic                 uop_ready,
	output trmce_pkg::uop_t      uop
);

	// floor reciprocal for the jump target reduction
	localparam int RECIP = 65536 / PROG_DEPTH;

	logic        ra_ok;
	logic        rb_ok;
	logic        m_ok;
	logic [24:0] tq_prod;

	assign uop_valid = in_valid;
	assign in_ready  = uop_ready;

	assign ra_ok   = {2'b00, in_data.first_reg} < 5'(NUM_REGS);
	assign rb_ok   = {2'b00, in_data.second_reg} < 5'(NUM_REGS);
	assign m_ok    = {7'd0, in_data.mem_address} < 13'(MEM_DEPTH);
	assign tq_prod = 25'(in_data.jump_target) * 25'(RECIP);

	always_comb begin
		uop           = '0;
		uop.bsel      = trmce_pkg::B_ZERO;
		uop.ra        = in_data.first_reg;
		uop.ra_ok     = ra_ok;
		uop.rb        = in_data.second_reg;
		uop.rb_ok     = rb_ok;
		uop.mem_addr  = in_data.mem_address;
		uop.mem_rd_ok = m_ok;
		uop.konst     = in_data.constant_value;
		uop.target    = in_data.jump_target;
		uop.tq        = tq_prod[23:16];
		case (in_data.mode)
			trmce_pkg::MODE_MOV: begin
				if (in_data.first_kind == trmce_pkg::FK_REG) begin
					case (in_data.second_kind)
						trmce_pkg::SK_REG: begin
							uop.reg_wr  = rb_ok;
							uop.reg_dst = in_data.second_reg;
							uop.bsel    = trmce_pkg::B_REGA;
						end
						trmce_pkg::SK_CONST: begin
							uop.reg_wr  = ra_ok;
							uop.reg_dst = in_data.first_reg;
							uop.bsel    = trmce_pkg::B_CONST;
						end
						trmce_pkg::SK_MEM: begin
							uop.mem_wr = m_ok;
							uop.bsel   = trmce_pkg::B_REGA;
						end
						default: ;
					endcase
				end else begin
					case (in_data.second_kind)
						trmce_pkg::SK_REG: begin
							uop.reg_wr  = rb_ok;
							uop.reg_dst = in_data.second_reg;
							uop.bsel    = trmce_pkg::B_MEM;
						end
						trmce_pkg::SK_CONST: begin
							uop.mem_wr = m_ok;
							uop.bsel   = trmce_pkg::B_CONST;
						end
						default: ;
					endcase
				end
			end
			trmce_pkg::MODE_ADD, trmce_pkg::MODE_SUB: begin
				if (in_data.first_kind == trmce_pkg::FK_REG) begin
					uop.bsel    = trmce_pkg::src_sel(in_data.second_kind);
					uop.reg_wr  = ra_ok && (uop.bsel != trmce_pkg::B_ZERO);
					uop.reg_dst = in_data.first_reg;
					uop.add_a   = 1'b1;
					uop.sub     = (in_data.mode == trmce_pkg::MODE_SUB);
				end
			end
			trmce_pkg::MODE_JZ:  uop.jmp_zero   = 1'b1;
			trmce_pkg::MODE_JNP: uop.jmp_nonpos = 1'b1;
			trmce_pkg::MODE_JMP: uop.jmp_any    = 1'b1;
			trmce_pkg::MODE_PRN: begin
				uop.print = 1'b1;
				uop.bsel  = trmce_pkg::src_sel(in_data.second_kind);
			end
			default: uop.halt = 1'b1;
		endcase
	end

endmodule

// ===== rtl/trmce_queue.sv =====
module trmce_queue (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            in_valid,
	output logic            in_ready,
	input  trmce_pkg::uop_t in_uop,
	output logic            out_valid,
	input  logic            out_ready,
	output trmce_pkg::uop_t out_uop
);

	trmce_pkg::uop_t entries_q [2];
	logic            wr_ptr_q;
	logic            rd_ptr_q;
	logic [1:0]      cnt_q;
	logic            push;
	logic            pop;

	assign in_ready  = (cnt_q != 2'd2);
	assign out_valid = (cnt_q != 2'd0);
	assign out_uop   = entries_q[rd_ptr_q];
	assign push      = in_valid && in_ready;
	assign pop       = out_valid && out_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			cnt_q    <= 2'd0;
		end else begin
			if (push) wr_ptr_q <= ~wr_ptr_q;
			if (pop)  rd_ptr_q <= ~rd_ptr_q;
			case ({push, pop})
				2'b10:   cnt_q <= cnt_q + 2'd1;
				2'b01:   cnt_q <= cnt_q - 2'd1;
				default: cnt_q <= cnt_q;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (push) entries_q[wr_ptr_q] <= in_uop;
	end

endmodule

// ===== rtl/trmce_back.sv =====
module trmce_back #(
	parameter int NUM_REGS   = 5,
	parameter int MEM_DEPTH  = 64,
	parameter int PROG_DEPTH = 256
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  uop_valid,
	output logic                  uop_ready,
	input  trmce_pkg::uop_t       uop,
	output logic                  out_valid,
	input  logic                  out_ready,
	output trmce_pkg::out_item_t  out_data,
	output trmce_pkg::back_stat_t stat
);

	// only the first eight registers and 64 words are reachable by the fields
	localparam int REG_WORDS = (NUM_REGS < 8) ? NUM_REGS : 8;
	localparam int RAW       = (REG_WORDS > 1) ? $clog2(REG_WORDS) : 1;
	localparam int MEM_WORDS = (MEM_DEPTH < 64) ? MEM_DEPTH : 64;
	localparam int MAW       = $clog2(MEM_WORDS);
	localparam int PCW       = $clog2(PROG_DEPTH);

	logic [31:0]         regs_q   [REG_WORDS];
	logic [31:0]         mem_q    [MEM_WORDS];
	logic                mvalid_q [MEM_WORDS];
	logic [PCW-1:0]      pc_q;
	logic                halt_q;
	logic                out_valid_q;
	trmce_pkg::out_item_t out_q;

	logic                valid_s1;
	trmce_pkg::uop_t     uop_s1;
	logic [31:0]         a_s1;
	logic [31:0]         rb_s1;
	logic [31:0]         mraw_s1;
	logic                mvld_s1;
	logic                mfwd_s1;
	logic [31:0]         mfwd_val_s1;

	logic                fire;
	logic                pop;
	logic                reg_we;
	logic                mem_we;
	logic [MAW-1:0]      widx;
	logic [MAW-1:0]      ridx;
	logic [31:0]         mval;
	logic [31:0]         b;
	logic [31:0]         opa;
	logic [31:0]         wval;
	logic                taken;
	logic [24:0]         tprod;
	logic [24:0]         trem;
	logic [PCW+7:0]      tgt_w;
	logic [PCW:0]        pc_inc;
	logic [PCW-1:0]      seq_pc;
	logic [PCW-1:0]      npc;
	logic [PCW+7:0]      npc_w;
	logic                halted_now;

	assign fire      = valid_s1 && (!out_valid_q || out_ready);
	assign uop_ready = !valid_s1 || fire;
	assign pop       = uop_valid && uop_ready;

	assign reg_we = fire && !halt_q && uop_s1.reg_wr;
	assign mem_we = fire && !halt_q && uop_s1.mem_wr;
	assign widx   = uop_s1.mem_addr[MAW-1:0];
	assign ridx   = uop.mem_addr[MAW-1:0];

	// memory word with write-through forwarding from the stage ahead
	assign mval = mfwd_s1 ? mfwd_val_s1 : (mvld_s1 ? mraw_s1 : 32'd0);

	always_comb begin
		case (uop_s1.bsel)
			trmce_pkg::B_REGA:  b = a_s1;
			trmce_pkg::B_REGB:  b = rb_s1;
			trmce_pkg::B_CONST: b = {1'b0, uop_s1.konst};
			trmce_pkg::B_MEM:   b = mval;
			default:            b = 32'd0;
		endcase
	end

	assign opa  = uop_s1.add_a ? a_s1 : 32'd0;
	assign wval = opa + (b ^ {32{uop_s1.sub}}) + {31'd0, uop_s1.sub};

	assign taken = uop_s1.jmp_any
		|| (uop_s1.jmp_zero && (a_s1 == 32'd0))
		|| (uop_s1.jmp_nonpos && ((a_s1 == 32'd0) || a_s1[31]));

	// target modulo program depth: estimate from the front, one correction here
	always_comb begin
		tprod = 25'(uop_s1.tq) * 25'(PROG_DEPTH);
		trem  = {17'd0, uop_s1.target} - tprod;
		if (trem >= 25'(PROG_DEPTH)) trem = trem - 25'(PROG_DEPTH);
	end

	assign tgt_w      = {{PCW{1'b0}}, trem[7:0]};
	assign pc_inc     = {1'b0, pc_q} + (PCW+1)'(1);
	assign seq_pc     = (pc_inc == (PCW+1)'(PROG_DEPTH)) ? '0 : pc_inc[PCW-1:0];
	assign halted_now = halt_q || uop_s1.halt;
	assign npc        = halted_now ? pc_q : (taken ? tgt_w[PCW-1:0] : seq_pc);
	assign npc_w      = {8'd0, npc};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1    <= 1'b0;
			halt_q      <= 1'b0;
			pc_q        <= '0;
			out_valid_q <= 1'b0;
			for (int i = 0; i < REG_WORDS; i++) regs_q[i] <= 32'd0;
			for (int i = 0; i < MEM_WORDS; i++) mvalid_q[i] <= 1'b0;
		end else begin
			if (uop_ready) valid_s1 <= uop_valid;
			if (fire) begin
				out_valid_q <= 1'b1;
				if (!halt_q) begin
					pc_q <= npc;
					if (uop_s1.halt) halt_q <= 1'b1;
				end
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
			if (reg_we) regs_q[uop_s1.reg_dst[RAW-1:0]] <= wval;
			if (mem_we) mvalid_q[widx] <= 1'b1;
		end
	end

	// execute stage payload and operand reads
	always_ff @(posedge clk) begin
		if (pop) begin
			uop_s1 <= uop;
			if (!uop.ra_ok)
				a_s1 <= 32'd0;
			else if (reg_we && (uop_s1.reg_dst == uop.ra))
				a_s1 <= wval;
			else
				a_s1 <= regs_q[uop.ra[RAW-1:0]];
			if (!uop.rb_ok)
				rb_s1 <= 32'd0;
			else if (reg_we && (uop_s1.reg_dst == uop.rb))
				rb_s1 <= wval;
			else
				rb_s1 <= regs_q[uop.rb[RAW-1:0]];
			mvld_s1     <= uop.mem_rd_ok && mvalid_q[ridx];
			mfwd_s1     <= uop.mem_rd_ok && mem_we && (uop_s1.mem_addr == uop.mem_addr);
			mfwd_val_s1 <= wval;
		end
		if (fire) begin
			out_q.next_pc     <= npc_w[7:0];
			out_q.halted_flag <= halted_now;
			out_q.print_valid <= !halt_q && uop_s1.print;
			out_q.print_value <= (!halt_q && uop_s1.print) ? b : 32'd0;
		end
	end

	// data memory
	always_ff @(posedge clk) begin
		if (mem_we) mem_q[widx] <= wval;
		if (pop) mraw_s1 <= mem_q[ridx];
	end

	assign out_valid       = out_valid_q;
	assign out_data        = out_q;
	assign stat.halted     = halt_q;
	assign stat.stage_full = valid_s1;

endmodule

// ===== rtl/tiny_register_memory_cpu_execute_core.sv =====
// executes one decoded instruction per item against five 32-bit registers, a
// 64-word data memory and a program counter; one item is taken per clock
// cycle for as long as results are drained, and an item's result passes
// through the queue write, the execute stage and the output register before
// it is offered; the rate is set by the single execute stage, which reads
// its operands from the register file and memory as the item enters it and
// forwards the previous item's register or memory write, so dependent items
// still run back to back; after a halt every item returns the held program
// counter with the halted flag set and changes nothing; registers, memory,
// pc and halt all come out of reset as zero, memory through per-word valid
// bits, so no clearing pass
`include "assert_macros.svh"

module tiny_register_memory_cpu_execute_core #(
	parameter int MEM_DEPTH  = 64,
	parameter int PROG_DEPTH = 256,
	parameter int NUM_REGS   = 5
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 in_valid,
	output logic                 in_ready,
	input  trmce_pkg::in_item_t  in_data,
	output logic                 out_valid,
	input  logic                 out_ready,
	output trmce_pkg::out_item_t out_data
);

	// front to queue
	logic                  fr_valid;
	logic                  fr_ready;
	trmce_pkg::uop_t       fr_uop;
	// queue to back
	logic                  q_valid;
	logic                  q_ready;
	trmce_pkg::uop_t       q_uop;
	trmce_pkg::back_stat_t bk_stat;

	// front: classify the instruction, range-check operands, start target reduction
	trmce_front #(
		.NUM_REGS   (NUM_REGS),
		.MEM_DEPTH  (MEM_DEPTH),
		.PROG_DEPTH (PROG_DEPTH)
	) u_front (
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.in_data   (in_data),
		.uop_valid (fr_valid),
		.uop_ready (fr_ready),
		.uop       (fr_uop)
	);

	// short queue so the front keeps taking items while the back stalls, until the queue is full
	trmce_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (fr_valid),
		.in_ready  (fr_ready),
		.in_uop    (fr_uop),
		.out_valid (q_valid),
		.out_ready (q_ready),
		.out_uop   (q_uop)
	);

	// back: operand read, execute, state update and result register
	trmce_back #(
		.NUM_REGS   (NUM_REGS),
		.MEM_DEPTH  (MEM_DEPTH),
		.PROG_DEPTH (PROG_DEPTH)
	) u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.uop_valid (q_valid),
		.uop_ready (q_ready),
		.uop       (q_uop),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.out_data  (out_data),
		.stat      (bk_stat)
	);

	// halt never clears once set
	`ASSERT_NEXT(a_halt_sticky, clk, arst_n, bk_stat.halted, bk_stat.halted)
	// a halted result implies the back has recorded the halt
	`ASSERT_IMPLIES(a_out_halt_state, clk, arst_n, out_valid && out_data.halted_flag, bk_stat.halted)
	// a print only happens before halt
	`ASSERT_IMPLIES(a_print_pre_halt, clk, arst_n, out_valid && out_data.print_valid, !out_data.halted_flag)
	// output register only fills from an occupied execute stage
	`ASSERT_IMPLIES(a_out_from_stage, clk, arst_n, $rose(out_valid), $past(bk_stat.stage_full))

endmodule
